/* rtl/qvr_pkg.sv */
// Shared constants for the quaternion vector rotation core.
`default_nettype none
package qvr_pkg;

    // Default field widths
    localparam int QVR_VEC_WIDTH  = 32;
    localparam int QVR_QUAT_WIDTH = 16;

    // Register stages from input word to output word
    localparam int QVR_LATENCY = 5;

    // Operation codes
    localparam logic QVR_OP_NAV2BODY = 1'b0;
    localparam logic QVR_OP_BODY2NAV = 1'b1;

endpackage : qvr_pkg
`default_nettype wire

/* rtl/qvr_in_if.sv */
// Input channel: operation, quaternion and vector with valid/ready.
`default_nettype none
interface qvr_in_if
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH,
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [VEC_WIDTH-1:0]  in_first;
    logic signed [VEC_WIDTH-1:0]  in_second;
    logic signed [VEC_WIDTH-1:0]  in_third;

    modport source (
        output valid, operation, quat_w, quat_x, quat_y, quat_z,
               in_first, in_second, in_third,
        input  ready
    );
    modport sink (
        input  valid, operation, quat_w, quat_x, quat_y, quat_z,
               in_first, in_second, in_third,
        output ready
    );
endinterface : qvr_in_if
`default_nettype wire

/* rtl/qvr_out_if.sv */
// Output channel: rotated vector and saturation flag with valid/ready.
`default_nettype none
interface qvr_out_if
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = QVR_VEC_WIDTH
) ();
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] out_first;
    logic signed [VEC_WIDTH-1:0] out_second;
    logic signed [VEC_WIDTH-1:0] out_third;
    logic                        saturated;

    modport source (
        output valid, out_first, out_second, out_third, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_first, out_second, out_third, saturated,
        output ready
    );
endinterface : qvr_out_if
`default_nettype wire

/* rtl/quaternion_vector_rotate_core.sv */
// Top level of the quaternion vector rotation core.
//
// Rotates a signed vector by the direction cosine matrix of an attitude
// quaternion: operation 0 applies C_n^b (NED to body), operation 1 its
// transpose (body to NED). The quaternion is used as given, so a non-unit
// quaternion scales the result by |q|^2. Each component is rounded half up,
// then clipped to the vector range; saturated is set when any component
// clipped. An input word passes through registered stages for quaternion
// products, matrix terms, per-lane multiplies, per-lane sum/round/clip, and
// the merging output register. One word is taken every cycle while the
// output side takes words; the five stages advance together, so a stall on
// the output holds the whole pipe and drops ready, even when bubbles sit in
// the earlier stages. No state survives between words, and reset only
// clears the valid bits.
`default_nettype none
module quaternion_vector_rotate_core
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH,
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qvr_in_if.sink    i_in,
    qvr_out_if.source o_out
);
    localparam int MAT_WIDTH = 2 * QUAT_WIDTH + 2;

    // valid bit per stage; the last one is the output word
    logic [QVR_LATENCY-1:0] r_vld;
    logic [QVR_LATENCY-1:0] n_vld;
    logic                   w_adv;

    logic signed [VEC_WIDTH-1:0] w_vin [3];
    logic signed [MAT_WIDTH-1:0] w_m [3][3];
    logic signed [VEC_WIDTH-1:0] w_v [3];
    logic signed [VEC_WIDTH-1:0] w_val [3];
    logic                        w_clip [3];

    // pipe moves when the output slot is empty or being drained
    assign w_adv      = !r_vld[QVR_LATENCY-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[QVR_LATENCY-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_vin[0] = i_in.in_first;
    assign w_vin[1] = i_in.in_second;
    assign w_vin[2] = i_in.in_third;

    // stages 1-2: matrix from the quaternion
    qvr_dcm #(
        .VEC_WIDTH  (VEC_WIDTH),
        .QUAT_WIDTH (QUAT_WIDTH),
        .MAT_WIDTH  (MAT_WIDTH)
    ) u_dcm (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_op  (i_in.operation),
        .i_qw  (i_in.quat_w),
        .i_qx  (i_in.quat_x),
        .i_qy  (i_in.quat_y),
        .i_qz  (i_in.quat_z),
        .i_v   (w_vin),
        .o_m   (w_m),
        .o_v   (w_v)
    );

    // stages 3-4: one lane per output component, each takes one matrix row
    for (genvar g = 0; g < 3; g++) begin : g_lane
        qvr_lane #(
            .VEC_WIDTH  (VEC_WIDTH),
            .QUAT_WIDTH (QUAT_WIDTH),
            .MAT_WIDTH  (MAT_WIDTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_m    (w_m[g]),
            .i_v    (w_v),
            .o_val  (w_val[g]),
            .o_clip (w_clip[g])
        );
    end

    // stage 5: output word
    qvr_merge #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_val    (w_val),
        .i_clip   (w_clip),
        .o_first  (o_out.out_first),
        .o_second (o_out.out_second),
        .o_third  (o_out.out_third),
        .o_sat    (o_out.saturated)
    );

    assign o_out.valid = r_vld[QVR_LATENCY-1];
endmodule : quaternion_vector_rotate_core
`default_nettype wire

/* rtl/qvr_dcm.sv */
// Quaternion to direction cosine matrix, two stages, with vector carried along.
`default_nettype none
module qvr_dcm
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH,
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH,
    parameter int MAT_WIDTH  = 2 * QUAT_WIDTH + 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic                         i_op,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qw,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qx,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qy,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qz,
    input  wire logic signed [VEC_WIDTH-1:0]  i_v [3],
    output logic signed [MAT_WIDTH-1:0]       o_m [3][3],
    output logic signed [VEC_WIDTH-1:0]       o_v [3]
);
    localparam int PW = 2 * QUAT_WIDTH;

    // stage 1: the ten quaternion products
    logic signed [PW-1:0] r_aa, r_bb, r_cc, r_dd, r_ab, r_ac, r_ad, r_bc, r_bd, r_cd;
    logic                 r_op;
    logic signed [VEC_WIDTH-1:0] r_v1 [3];

    // stage 2: selected matrix
    logic signed [MAT_WIDTH-1:0] r_m [3][3];
    logic signed [VEC_WIDTH-1:0] r_v2 [3];

    logic signed [MAT_WIDTH-1:0] w_nb [3][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa <= PW'(i_qw) * PW'(i_qw);
            r_bb <= PW'(i_qx) * PW'(i_qx);
            r_cc <= PW'(i_qy) * PW'(i_qy);
            r_dd <= PW'(i_qz) * PW'(i_qz);
            r_ab <= PW'(i_qw) * PW'(i_qx);
            r_ac <= PW'(i_qw) * PW'(i_qy);
            r_ad <= PW'(i_qw) * PW'(i_qz);
            r_bc <= PW'(i_qx) * PW'(i_qy);
            r_bd <= PW'(i_qx) * PW'(i_qz);
            r_cd <= PW'(i_qy) * PW'(i_qz);
            r_op <= i_op;
            r_v1 <= i_v;
        end
    end

    // C_n^b terms; off-diagonal ones carry the factor of two as a shift
    always_comb begin
        w_nb[0][0] = MAT_WIDTH'(r_aa) + MAT_WIDTH'(r_bb) - MAT_WIDTH'(r_cc) - MAT_WIDTH'(r_dd);
        w_nb[1][1] = MAT_WIDTH'(r_aa) - MAT_WIDTH'(r_bb) + MAT_WIDTH'(r_cc) - MAT_WIDTH'(r_dd);
        w_nb[2][2] = MAT_WIDTH'(r_aa) - MAT_WIDTH'(r_bb) - MAT_WIDTH'(r_cc) + MAT_WIDTH'(r_dd);
        w_nb[0][1] = (MAT_WIDTH'(r_bc) + MAT_WIDTH'(r_ad)) <<< 1;
        w_nb[0][2] = (MAT_WIDTH'(r_bd) - MAT_WIDTH'(r_ac)) <<< 1;
        w_nb[1][0] = (MAT_WIDTH'(r_bc) - MAT_WIDTH'(r_ad)) <<< 1;
        w_nb[1][2] = (MAT_WIDTH'(r_cd) + MAT_WIDTH'(r_ab)) <<< 1;
        w_nb[2][0] = (MAT_WIDTH'(r_bd) + MAT_WIDTH'(r_ac)) <<< 1;
        w_nb[2][1] = (MAT_WIDTH'(r_cd) - MAT_WIDTH'(r_ab)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m[i][j] <= (r_op == QVR_OP_BODY2NAV) ? w_nb[j][i] : w_nb[i][j];
                end
            end
            r_v2 <= r_v1;
        end
    end

    assign o_m = r_m;
    assign o_v = r_v2;
endmodule : qvr_dcm
`default_nettype wire

/* rtl/qvr_lane.sv */
// One output component: row-by-vector products, then round and saturate.
`default_nettype none
module qvr_lane
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH,
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH,
    parameter int MAT_WIDTH  = 2 * QUAT_WIDTH + 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [MAT_WIDTH-1:0] i_m [3],
    input  wire logic signed [VEC_WIDTH-1:0] i_v [3],
    output logic signed [VEC_WIDTH-1:0]      o_val,
    output logic                             o_clip
);
    localparam int PRW   = MAT_WIDTH + VEC_WIDTH;
    localparam int AW    = PRW + 2;
    localparam int SHIFT = 2 * (QUAT_WIDTH - 2);
    localparam int TW    = AW - SHIFT;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SHIFT - 1);
    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic signed [PRW-1:0]       r_p [3];
    logic signed [VEC_WIDTH-1:0] r_val;
    logic                        r_clip;

    logic signed [AW-1:0]        w_sum;
    logic signed [TW-1:0]        w_trunc;
    logic                        w_fits;
    logic signed [VEC_WIDTH-1:0] n_val;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p[j] <= PRW'(i_m[j]) * PRW'(i_v[j]);
            end
        end
    end

    // round half up, drop the matrix fraction, clip to vector range
    always_comb begin
        w_sum   = AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]) + HALF;
        w_trunc = w_sum[AW-1:SHIFT];
        w_fits  = (&w_trunc[TW-1:VEC_WIDTH-1]) || !(|w_trunc[TW-1:VEC_WIDTH-1]);
        if (w_fits) begin
            n_val = w_trunc[VEC_WIDTH-1:0];
        end else if (w_trunc[TW-1]) begin
            n_val = VMIN;
        end else begin
            n_val = VMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= n_val;
            r_clip <= !w_fits;
        end
    end

    assign o_val  = r_val;
    assign o_clip = r_clip;
endmodule : qvr_lane
`default_nettype wire

/* rtl/qvr_merge.sv */
// Output register: gathers the three lanes and combines their clip flags.
`default_nettype none
module qvr_merge
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = QVR_VEC_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [VEC_WIDTH-1:0] i_val [3],
    input  wire logic                        i_clip [3],
    output logic signed [VEC_WIDTH-1:0]      o_first,
    output logic signed [VEC_WIDTH-1:0]      o_second,
    output logic signed [VEC_WIDTH-1:0]      o_third,
    output logic                             o_sat
);
    logic signed [VEC_WIDTH-1:0] r_first, r_second, r_third;
    logic                        r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first  <= i_val[0];
            r_second <= i_val[1];
            r_third  <= i_val[2];
            r_sat    <= i_clip[0] | i_clip[1] | i_clip[2];
        end
    end

    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_third  = r_third;
    assign o_sat    = r_sat;
endmodule : qvr_merge
`default_nettype wire

/* bench/quaternion_vector_rotate_checker.sv */
// Watches both channels of the rotation core, predicts each result word and compares it.
module quaternion_vector_rotate_checker
    import qvr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qvr_in_if         i_cmd,
    qvr_out_if        i_res,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_results,
    output int        o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW     = QVR_VEC_WIDTH;
    localparam int QW     = QVR_QUAT_WIDTH;
    localparam int SHIFT  = 2 * (QW - 2);
    localparam int ACC_W  = 128;
    localparam int REPORT_LIMIT = 200;

    localparam logic signed [ACC_W-1:0] ACC_ONE  = 1;
    localparam logic signed [ACC_W-1:0] LANE_MAX = (ACC_ONE <<< (VW - 1)) - ACC_ONE;
    localparam logic signed [ACC_W-1:0] LANE_MIN = -(ACC_ONE <<< (VW - 1));

    typedef struct packed {
        logic signed [VW-1:0] first;
        logic signed [VW-1:0] second;
        logic signed [VW-1:0] third;
        logic                 saturated;
    } rotation_t;

    rotation_t expected_rotations [$];
    int mismatch_count = 0;
    int pending_count  = 0;
    int result_count   = 0;
    int clip_count     = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_results    = result_count;
    assign o_clipped    = clip_count;

    // Direction cosine matrix from the raw quaternion, then M*v or M'*v,
    // summed exactly, rounded half up and clipped per lane.
    function automatic rotation_t rotate_vector(
        input logic                  op,
        input logic signed [QW-1:0]  qw, qx, qy, qz,
        input logic signed [VW-1:0]  v0, v1, v2
    );
        logic signed [63:0]      a, b, c, d;
        logic signed [63:0]      dcm [3][3];
        logic signed [ACC_W-1:0] vec [3];
        logic signed [ACC_W-1:0] acc;
        logic signed [VW-1:0]    lane [3];
        logic                    clip;
        rotation_t               r;
        a = qw;
        b = qx;
        c = qy;
        d = qz;
        vec[0] = v0;
        vec[1] = v1;
        vec[2] = v2;
        dcm[0][0] = a * a + b * b - c * c - d * d;
        dcm[0][1] = 2 * (b * c + a * d);
        dcm[0][2] = 2 * (b * d - a * c);
        dcm[1][0] = 2 * (b * c - a * d);
        dcm[1][1] = a * a - b * b + c * c - d * d;
        dcm[1][2] = 2 * (c * d + a * b);
        dcm[2][0] = 2 * (b * d + a * c);
        dcm[2][1] = 2 * (c * d - a * b);
        dcm[2][2] = a * a - b * b - c * c + d * d;
        clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                acc += (op == QVR_OP_BODY2NAV ? dcm[j][i] : dcm[i][j]) * vec[j];
            end
            acc = (acc + (ACC_ONE <<< (SHIFT - 1))) >>> SHIFT;
            if (acc > LANE_MAX) begin
                lane[i] = LANE_MAX[VW-1:0];
                clip    = 1'b1;
            end else if (acc < LANE_MIN) begin
                lane[i] = LANE_MIN[VW-1:0];
                clip    = 1'b1;
            end else begin
                lane[i] = acc[VW-1:0];
            end
        end
        r.first     = lane[0];
        r.second    = lane[1];
        r.third     = lane[2];
        r.saturated = clip;
        return r;
    endfunction

    task automatic compare_field(
        input string               field,
        input logic signed [VW-1:0] want,
        input logic signed [VW-1:0] got
    );
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            end else if (mismatch_count == REPORT_LIMIT + 1) begin
                $display("%0t ns: further mismatches counted but not shown", $time);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        rotation_t want;
        if (i_rst_n) begin
            // Results first: the pipe is deeper than one stage, so a word
            // accepted on this edge can never be the one leaving.
            if (i_res.valid && i_res.ready) begin
                result_count++;
                if (i_res.saturated === 1'b1) begin
                    clip_count++;
                end
                if (expected_rotations.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result word with nothing expected: %0d %0d %0d sat %0b",
                             $time, i_res.out_first, i_res.out_second, i_res.out_third,
                             i_res.saturated);
                end else begin
                    want = expected_rotations.pop_front();
                    compare_field("out_first",  want.first,  i_res.out_first);
                    compare_field("out_second", want.second, i_res.out_second);
                    compare_field("out_third",  want.third,  i_res.out_third);
                    compare_field("saturated",  VW'(want.saturated), VW'(i_res.saturated));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_rotations.push_back(rotate_vector(
                    i_cmd.operation, i_cmd.quat_w, i_cmd.quat_x, i_cmd.quat_y,
                    i_cmd.quat_z, i_cmd.in_first, i_cmd.in_second, i_cmd.in_third));
            end
            pending_count = expected_rotations.size();
        end
    end

endmodule : quaternion_vector_rotate_checker

/* bench/quaternion_vector_rotate_core_test.sv */
// Testbench top for the quaternion vector rotation core: stimulus, pressure and verdict.
module quaternion_vector_rotate_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qvr_pkg::*;

    localparam int VW             = QVR_VEC_WIDTH;
    localparam int QW             = QVR_QUAT_WIDTH;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_MAX       = 16;
    // Output hold-off long enough to fill all five stages many times over.
    localparam int STALL_CYCLES   = 200;
    // Longest legal quiet stretch is the hold-off above; allow a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int QUAT_ONE       = 1 << (QW - 2);
    // Roughly cos(45 deg) in Q2.14, for quarter-turn rotations.
    localparam int QUAT_HALF_TURN = 11585;

    localparam logic signed [QW-1:0] QUAT_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QUAT_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [VW-1:0] VEC_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VEC_MIN  = {1'b1, {(VW-1){1'b0}}};

    // Quaternion parts at field width for directed words.
    localparam logic signed [QW-1:0] Q_ZERO   = '0;
    localparam logic signed [QW-1:0] Q_ONE    = QW'(QUAT_ONE);
    localparam logic signed [QW-1:0] Q_HALF   = QW'(QUAT_ONE / 2);
    localparam logic signed [QW-1:0] Q_COS45  = QW'(QUAT_HALF_TURN);

    typedef struct packed {
        logic                 op;
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic signed [VW-1:0] v0;
        logic signed [VW-1:0] v1;
        logic signed [VW-1:0] v2;
    } rotate_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    // Idling knobs, flipped per phase by the stimulus process.
    bit src_idle     = 1'b1;
    bit snk_idle     = 1'b1;
    bit hold_request = 1'b0;

    int sent_nav2body = 0;
    int sent_body2nav = 0;
    int quiet_cycles  = 0;

    int mismatches;
    int pending;
    int results;
    int clipped;

    qvr_in_if  in_ch ();
    qvr_out_if out_ch ();

    quaternion_vector_rotate_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    quaternion_vector_rotate_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (in_ch),
        .i_res        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_clipped    (clipped)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Word construction
    // ------------------------------------------------------------------

    function automatic rotate_cmd_t pack_cmd(
        input logic                 op,
        input logic signed [QW-1:0] w, x, y, z,
        input logic signed [VW-1:0] v0, v1, v2
    );
        rotate_cmd_t cmd;
        cmd.op = op;
        cmd.w  = w;
        cmd.x  = x;
        cmd.y  = y;
        cmd.z  = z;
        cmd.v0 = v0;
        cmd.v1 = v1;
        cmd.v2 = v2;
        return cmd;
    endfunction

    // Random direction, scaled to unit length in Q2.14. Keeps the matrix
    // near orthonormal so most results stay in range and rounding shows.
    function automatic logic [4*QW-1:0] unit_quat();
        int                raw [4];
        real               norm;
        logic [4*QW-1:0]   q;
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
            raw[k] = $urandom_range(0, 2 * QUAT_ONE);
            raw[k] = raw[k] - QUAT_ONE;
            norm += $itor(raw[k]) * $itor(raw[k]);
        end
        if (norm < 1.0) begin
            return {QW'(QUAT_ONE), {(3*QW){1'b0}}};
        end
        norm = $sqrt(norm);
        for (int k = 0; k < 4; k++) begin
            q[k*QW +: QW] = QW'($rtoi($itor(raw[k]) * $itor(QUAT_ONE) / norm));
        end
        return q;
    endfunction

    function automatic logic signed [QW-1:0] quat_corner();
        unique case ($urandom_range(0, 4))
            0:       return QUAT_MIN;
            1:       return QUAT_MAX;
            2:       return '0;
            3:       return QW'(QUAT_ONE);
            default: return QW'(-QUAT_ONE);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] vec_corner();
        unique case ($urandom_range(0, 4))
            0:       return VEC_MIN;
            1:       return VEC_MAX;
            2:       return '0;
            3:       return '1;
            default: return VW'(1);
        endcase
    endfunction

    // Mix of word shapes:
    //   full random fields - every bit toggles, mostly clipped results
    //   unit quaternion with moderate vectors - exact rotation and rounding
    //   shrunken quaternion with vectors of every magnitude - near the clip edge
    //   corners of every field
    function automatic rotate_cmd_t random_cmd();
        rotate_cmd_t cmd;
        int          kind;
        int          shrink;
        kind   = $urandom_range(0, 9);
        cmd.op = 1'($urandom_range(0, 1));
        cmd.w  = QW'($urandom);
        cmd.x  = QW'($urandom);
        cmd.y  = QW'($urandom);
        cmd.z  = QW'($urandom);
        cmd.v0 = VW'($urandom);
        cmd.v1 = VW'($urandom);
        cmd.v2 = VW'($urandom);
        if (kind >= 4 && kind <= 6) begin
            {cmd.w, cmd.x, cmd.y, cmd.z} = unit_quat();
            cmd.v0 = cmd.v0 >>> $urandom_range(4, 20);
            cmd.v1 = cmd.v1 >>> $urandom_range(4, 20);
            cmd.v2 = cmd.v2 >>> $urandom_range(4, 20);
        end else if (kind >= 7 && kind <= 8) begin
            {cmd.w, cmd.x, cmd.y, cmd.z} = unit_quat();
            shrink = $urandom_range(0, 4);
            cmd.w  = cmd.w >>> shrink;
            cmd.x  = cmd.x >>> shrink;
            cmd.y  = cmd.y >>> shrink;
            cmd.z  = cmd.z >>> shrink;
            cmd.v0 = cmd.v0 >>> $urandom_range(0, VW - 1);
            cmd.v1 = cmd.v1 >>> $urandom_range(0, VW - 1);
            cmd.v2 = cmd.v2 >>> $urandom_range(0, VW - 1);
        end else if (kind == 9) begin
            cmd.w  = quat_corner();
            cmd.x  = quat_corner();
            cmd.y  = quat_corner();
            cmd.z  = quat_corner();
            cmd.v0 = vec_corner();
            cmd.v1 = vec_corner();
            cmd.v2 = vec_corner();
        end
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word and return at the edge where it is taken. A gap
    // drops valid first; with no gap valid stays high back to back, so
    // valid only ever gets one assignment per edge.
    task automatic offer_word(input rotate_cmd_t cmd);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= cmd.op;
        in_ch.quat_w    <= cmd.w;
        in_ch.quat_x    <= cmd.x;
        in_ch.quat_y    <= cmd.y;
        in_ch.quat_z    <= cmd.z;
        in_ch.in_first  <= cmd.v0;
        in_ch.in_second <= cmd.v1;
        in_ch.in_third  <= cmd.v2;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (cmd.op == QVR_OP_BODY2NAV) begin
            sent_body2nav++;
        end else begin
            sent_nav2body++;
        end
    endtask

    task automatic run_words(input int count);
        for (int n = 0; n < count; n++) begin
            offer_word(random_cmd());
        end
    endtask

    // Stop offering until every expected result is out, then let the
    // pipe settle. The checker updates its count on the clock edge, so
    // look at it on the falling edge.
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (QVR_LATENCY + 4) @(posedge clk);
    endtask

    initial begin : stimulus
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= QVR_OP_NAV2BODY;
        in_ch.quat_w    <= '0;
        in_ch.quat_x    <= '0;
        in_ch.quat_y    <= '0;
        in_ch.quat_z    <= '0;
        in_ch.in_first  <= '0;
        in_ch.in_second <= '0;
        in_ch.in_third  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. Identity in both directions.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                            65536, 131072, 196608));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                            65536, 131072, 196608));
        // Quarter turns about each axis.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_COS45, Q_ZERO, Q_ZERO, Q_COS45,
                            65536, 0, 0));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_COS45, Q_ZERO, Q_ZERO, Q_COS45,
                            65536, 0, 0));
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_COS45, Q_COS45, Q_ZERO, Q_ZERO,
                            0, 65536, 0));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_COS45, Q_ZERO, Q_COS45, Q_ZERO,
                            0, 0, 65536));
        // Vector extremes pass through identity unclipped.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                            VEC_MAX, VEC_MIN, -1));
        // Non-unit quaternion: |q|^2 = 4 pushes both ends out of range.
        offer_word(pack_cmd(QVR_OP_BODY2NAV, QUAT_MIN, Q_ZERO, Q_ZERO, Q_ZERO,
                            VEC_MAX, VEC_MIN, 1));
        // Overflow at either end with all parts at their extremes.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX,
                            VEC_MAX, VEC_MAX, VEC_MAX));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN,
                            VEC_MIN, VEC_MIN, VEC_MIN));
        // Zero quaternion kills the vector.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                            VEC_MAX, VEC_MIN, VEC_MAX));
        // Quarter-scale diagonal: halves round up, including negative halves.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, 2, -2, 6));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, -6, 3, -3));
        // Alternating extremes, mixed signs.
        offer_word(pack_cmd(QVR_OP_NAV2BODY, QUAT_MAX, QUAT_MIN, QUAT_MAX, QUAT_MIN,
                            123456, -654321, 777));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, QUAT_MIN, QUAT_MAX, QUAT_MIN, QUAT_MAX,
                            1, -1, 0));
        offer_word(pack_cmd(QVR_OP_NAV2BODY, QW'(100), QW'(200), QW'(-300), QW'(400),
                            VEC_MAX, VEC_MIN, VEC_MAX));
        // Single vector part set: diagonal terms alone, off-diagonal ones zero.
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_ZERO, QUAT_MAX, Q_ZERO, Q_ZERO,
                            123456789, -987654321, 555));
        offer_word(pack_cmd(QVR_OP_NAV2BODY, Q_ZERO, Q_ZERO, QUAT_MIN, Q_ZERO,
                            -5, 70000, VEC_MIN));
        offer_word(pack_cmd(QVR_OP_BODY2NAV, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
                            -65536, 65536, 42));
        drain_pipe();

        // Random words, both sides idling at random.
        run_words(680);

        // Stretch with no idling on either side.
        src_idle = 1'b0;
        snk_idle = 1'b0;
        run_words(300);

        // Long output hold-off while words keep coming: pipe fills and
        // input ready must drop until the output side resumes.
        hold_request = 1'b1;
        run_words(40);

        // Sender waits for every result before going on.
        drain_pipe();

        // Fast sender against a slow receiver, then the reverse.
        snk_idle = 1'b1;
        run_words(400);
        src_idle = 1'b1;
        snk_idle = 1'b0;
        run_words(400);

        drain_pipe();

        $display("Sent %0d words (%0d NED to body, %0d body to NED);",
                 sent_nav2body + sent_body2nav, sent_nav2body, sent_body2nav);
        $display("%0d results checked, %0d clipped.", results, clipped);
        $display("Random idling both ways, a %0d-cycle output hold-off and drained pauses.",
                 STALL_CYCLES);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // One draw per result word: a random wait, none, or the long hold-off
    // when asked for. Ready stays high until a word is taken.
    initial begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                gap          = STALL_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = snk_idle ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any word moving on either side resets the count.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule : quaternion_vector_rotate_core_test

/* files.f */
rtl/qvr_pkg.sv
rtl/qvr_in_if.sv
rtl/qvr_out_if.sv
rtl/qvr_dcm.sv
rtl/qvr_lane.sv
rtl/qvr_merge.sv
rtl/quaternion_vector_rotate_core.sv
bench/quaternion_vector_rotate_checker.sv
bench/quaternion_vector_rotate_core_test.sv
